// ===== src/sfas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_pkg
// shared types and constants for the truncating single-precision add/sub
// ----------------------------------------------------------------------------
package sfas_pkg;

    localparam int unsigned ManBits   = 23;
    localparam int unsigned SearchTop = 25;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_SUB = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [31:0] sum_bits;
    } t_rsp;

endpackage

// ===== src/sfas_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_req_if / sfas_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface sfas_req_if;
    logic            valid;
    logic            ready;
    sfas_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfas_rsp_if;
    logic            valid;
    logic            ready;
    sfas_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/sfas_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_core
// combinational align, add/subtract and truncating normalize
// ----------------------------------------------------------------------------
module sfas_core (
    input  sfas_pkg::t_req i_req,
    output logic [31:0]    o_sum
);

    logic [31:0] x, y, big, lit;
    logic [30:0] magx, magy;
    logic        sbig, ssmall;
    logic [7:0]  ebig, esmall, shft;
    logic [23:0] mbig, msmall, mshift;
    logic [24:0] raw;
    logic [4:0]  pos;
    logic [4:0]  d;
    logic [8:0]  expo;
    logic [24:0] frac;
    logic        swap;

    always_comb begin
        x = i_req.operand_a;
        y = i_req.operand_b ^ {(i_req.req_type == sfas_pkg::REQ_SUB), 31'd0};
        magx = x[30:0];
        magy = y[30:0];
        swap = magy > magx;
        big = swap ? y : x;
        lit = swap ? x : y;
        sbig = big[31];
        ssmall = lit[31];
        ebig = big[30:23];
        esmall = lit[30:23];
        shft = ebig - esmall;
        mbig = {1'b1, big[22:0]};
        msmall = {1'b1, lit[22:0]};
        mshift = (shft >= 8'd24) ? 24'd0 : (msmall >> shft[4:0]);
        raw = (sbig != ssmall) ? ({1'b0, mbig} - {1'b0, mshift})
                               : ({1'b0, mbig} + {1'b0, mshift});
        pos = 5'd0;
        for (int i = 1; i <= 24; i++) begin
            if (raw[i]) begin
                pos = 5'(i);
            end
        end
        if (pos >= 5'd23) begin
            d = pos - 5'd23;
            expo = {1'b0, ebig} + {4'd0, d};
            frac = raw >> d;
        end else begin
            d = 5'd23 - pos;
            expo = {1'b0, ebig} - {4'd0, d};
            frac = raw << d;
        end
        if (magx == magy && sbig != ssmall) begin
            o_sum = 32'd0;
        end else begin
            o_sum = {sbig | expo[8], expo[7:0], frac[22:0]};
        end
    end

endmodule

// ===== src/single_float_add_sub_truncating.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_float_add_sub_truncating
// stages: input reg, then result reg, with the combinational core between them
// throughput: one beat per cycle while results are taken, limited by the single-pass core
// a held result does not block a new input while the input stage is free
// reset (synchronous, active low) clears both stage valid flags
// ----------------------------------------------------------------------------
module single_float_add_sub_truncating (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfas_req_if.sink    i_req,
    sfas_rsp_if.source  o_rsp
);

    logic           r_in_vld, n_in_vld;
    sfas_pkg::t_req r_in;
    logic           r_out_vld, n_out_vld;
    logic [31:0]    r_out;
    logic [31:0]    core_sum;
    logic           out_free;

    sfas_core u_core (.i_req(r_in), .o_sum(core_sum));

    assign out_free = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_in_vld || out_free;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data.sum_bits = r_out;

    always_comb begin
        n_in_vld = i_req.valid ? 1'b1 : (r_in_vld && !out_free);
        if (!i_req.ready) n_in_vld = r_in_vld;
        n_out_vld = (r_in_vld && out_free) ? 1'b1 : (r_out_vld && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
        if (i_req.valid && i_req.ready) r_in <= i_req.data;
        if (r_in_vld && out_free) r_out <= core_sum;
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_rsp.ready |=> r_out_vld && $stable(r_out))
        else $error("result lost under stall");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !out_free |=> r_in_vld)
        else $error("input stage dropped");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && out_free |=> r_out_vld)
        else $error("result not registered");

endmodule

// ===== tb/single_float_add_sub_truncating_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_float_add_sub_truncating_test
// drives add/sub beats through the truncating single-precision adder with
// random gaps and result back-pressure, predicts each sum and compares it
// ----------------------------------------------------------------------------
module single_float_add_sub_truncating_test;

    localparam int NumRandom = 1030;
    localparam int NumDirected = 22;

    logic i_clk;
    logic i_rst_n;

    sfas_req_if req_ch ();
    sfas_rsp_if rsp_ch ();

    single_float_add_sub_truncating uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    typedef struct {
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
        logic        known;
        logic [31:0] sum;
    } t_row;

    t_row        rows [NumDirected];
    logic [31:0] sum_queue [$];
    int          errors = 0;
    int          sums_seen = 0;
    int          beats_sent = 0;
    bit          quiet_tail = 0;
    bit          sending_done = 0;
    bit          hold_done = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] fp_sum(logic op, logic [31:0] x, logic [31:0] y);
        logic [31:0] big, lit, mbig, mlit, raw, frac;
        logic [30:0] magx, magy;
        logic [7:0]  ebig, elit, shft;
        logic [8:0]  expo;
        int          pos, d;
        if (op == sfas_pkg::REQ_SUB) y[31] = ~y[31];
        magx = x[30:0];
        magy = y[30:0];
        if (magy > magx) begin
            big = y;
            lit = x;
        end else begin
            big = x;
            lit = y;
        end
        if (magx == magy && big[31] != lit[31]) return 32'h0;
        ebig = big[30:23];
        elit = lit[30:23];
        shft = ebig - elit;
        mbig = {9'b1, big[22:0]};
        mlit = {9'b1, lit[22:0]};
        mlit = (shft >= 32) ? 32'h0 : (mlit >> shft);
        raw = (big[31] != lit[31]) ? mbig - mlit : mbig + mlit;
        pos = sfas_pkg::SearchTop;
        while (pos > 0 && !raw[pos]) pos--;
        if (pos >= sfas_pkg::ManBits) begin
            d = pos - sfas_pkg::ManBits;
            expo = {1'b0, ebig} + 9'(d);
            frac = raw >> d;
        end else begin
            d = sfas_pkg::ManBits - pos;
            expo = {1'b0, ebig} - 9'(d);
            frac = raw << d;
        end
        return {big[31] | expo[8], expo[7:0], frac[22:0]};
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %08h want %08h", what, got, want);
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 4))
            0: v[30:23] = 8'($urandom_range(120, 135));
            1: v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_beat(logic op, logic [31:0] a, logic [31:0] b);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.data <= '{req_type: op, operand_a: a, operand_b: b};
        sum_queue.push_back(fp_sum(op, a, b));
        do @(posedge i_clk); while (!req_ch.ready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] a, b, pb;
        rows = '{
            '{sfas_pkg::REQ_ADD, 32'h3f800000, 32'h3f800000, 1'b1, 32'h40000000},
            '{sfas_pkg::REQ_SUB, 32'h3f800000, 32'h3f800000, 1'b1, 32'h00000000},
            '{sfas_pkg::REQ_ADD, 32'h3f800000, 32'hbf800000, 1'b1, 32'h00000000},
            '{sfas_pkg::REQ_ADD, 32'h40400000, 32'h3f800000, 1'b1, 32'h40800000},
            '{sfas_pkg::REQ_SUB, 32'h40400000, 32'h3f800000, 1'b1, 32'h40000000},
            '{sfas_pkg::REQ_ADD, 32'h00000000, 32'h00000000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0},
            '{sfas_pkg::REQ_SUB, 32'hffffffff, 32'h7fffffff, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h7f800000, 32'h00000000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h4f800000, 32'h3f800000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h4f000000, 32'h3f800000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_SUB, 32'h3f800001, 32'h3f800000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_SUB, 32'h00800000, 32'h3f800000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h7f7fffff, 32'h7f7fffff, 1'b0, 32'h0},
            '{sfas_pkg::REQ_SUB, 32'h3fffffff, 32'h3f800000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h80000000, 32'h00000000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_SUB, 32'h00000001, 32'h00000000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0},
            '{sfas_pkg::REQ_SUB, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h3f800000, 32'h3f000000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_SUB, 32'h3f000000, 32'h3f800000, 1'b0, 32'h0},
            '{sfas_pkg::REQ_ADD, 32'h7fffffff, 32'h00000000, 1'b0, 32'h0}
        };
        foreach (rows[i])
            if (rows[i].known && fp_sum(rows[i].op, rows[i].a, rows[i].b) != rows[i].sum)
                report("table row", fp_sum(rows[i].op, rows[i].a, rows[i].b), rows[i].sum);
        i_rst_n = 0;
        req_ch.valid = 0;
        req_ch.data = '0;
        pb = 32'h3f800000;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        foreach (rows[i]) send_beat(rows[i].op, rows[i].a, rows[i].b);
        for (int n = 0; n < NumRandom; n++) begin
            if (n > NumRandom - 150) quiet_tail = 1;
            a = rand_operand();
            case ($urandom_range(0, 5))
                0: b = a ^ (32'h1 << $urandom_range(0, 31));
                1: b = {$urandom_range(0, 1) ? 1'b1 : 1'b0, a[30:0]};
                2: b = pb;
                default: b = rand_operand();
            endcase
            pb = a;
            send_beat(1'($urandom_range(0, 1)), a, b);
        end
        req_ch.valid <= 0;
        sending_done = 1;
    end

    initial begin
        int hold_left;
        rsp_ch.ready = 0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && beats_sent > 200) begin
                rsp_ch.ready <= 0;
                hold_done = 1;
                hold_left = 300;
            end else if (hold_left > 0) begin
                hold_left--;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 0;
                hold_left = $urandom_range(0, 17);
            end else begin
                rsp_ch.ready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sums_seen++;
            if (sum_queue.size() == 0)
                report("unexpected beat", rsp_ch.data.sum_bits, 32'h0);
            else if (rsp_ch.data.sum_bits !== sum_queue[0])
                report("sum_bits", rsp_ch.data.sum_bits, sum_queue.pop_front());
            else
                void'(sum_queue.pop_front());
        end
    end

    initial begin
        wait (sending_done);
        wait (sum_queue.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("covered %0d add/sub beats, %0d sums checked, incl. long result stall",
                 beats_sent, sums_seen);
        if (errors == 0 && sum_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/sfas_pkg.sv
src/sfas_if.sv
src/sfas_core.sv
src/single_float_add_sub_truncating.sv
tb/single_float_add_sub_truncating_test.sv
